FILE: sv/base64_decoder_core_macros.svh
// Assertion macros shared by the decoder modules.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef BASE64_DECODER_CORE_MACROS_SVH
`define BASE64_DECODER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define B64_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("base64 decoder: same-cycle check failed");
`define B64_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("base64 decoder: next-cycle check failed");
`else
`define B64_ASSERT_IMPLIES(lbl, ante, cons)
`define B64_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: sv/b64_pkg.sv
package b64_pkg;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_UNDER   = 8'h5F;

  localparam logic [1:0] POS_FIRST  = 2'd0;
  localparam logic [1:0] POS_SECOND = 2'd1;
  localparam logic [1:0] POS_THIRD  = 2'd2;
  localparam logic [1:0] POS_FOURTH = 2'd3;

  typedef struct packed {
    logic       valid;
    logic [5:0] value;
    logic       final_req;
  } sym_class_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_text;
    logic       halted;
  } result_t;

  function automatic sym_class_t classify(input logic [7:0] sym, input logic url_safe,
                                          input logic final_req);
    sym_class_t c;
    c.valid     = 1'b1;
    c.value     = 6'd0;
    c.final_req = final_req;
    if (sym >= CH_UPPER_A && sym <= CH_UPPER_Z) begin
      c.value = 6'(sym - CH_UPPER_A);
    end else if (sym >= CH_LOWER_A && sym <= CH_LOWER_Z) begin
      c.value = 6'(sym - CH_LOWER_A + 8'd26);
    end else if (sym >= CH_DIGIT_0 && sym <= CH_DIGIT_9) begin
      c.value = 6'(sym - CH_DIGIT_0 + 8'd52);
    end else if (sym == CH_PLUS || (url_safe && sym == CH_MINUS)) begin
      c.value = 6'd62;
    end else if (sym == CH_SLASH || (url_safe && sym == CH_UNDER)) begin
      c.value = 6'd63;
    end else begin
      c.valid = 1'b0;
    end
    return c;
  endfunction

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

FILE: sv/b64_front.sv
`include "base64_decoder_core_macros.svh"

module b64_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic                  cfg_wdata,
  input  logic                  push,
  output logic                  full,
  input  logic [7:0]            in_symbol,
  input  logic                  in_final_req,
  output logic                  cq_empty,
  input  logic                  cq_pop,
  output b64_pkg::sym_class_t   cq_head
);

  logic                        url_safe_r;
  b64_pkg::sym_class_t         q_r [b64_pkg::QDEPTH];
  logic [b64_pkg::QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [b64_pkg::QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [b64_pkg::QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic                        wr_en;
  logic                        rd_en;

  assign full     = (cnt_r == b64_pkg::QCNT_W'(b64_pkg::QDEPTH));
  assign cq_empty = (cnt_r == '0);
  assign cq_head  = q_r[rd_ptr_r];
  assign wr_en    = push && !full;
  assign rd_en    = cq_pop && !cq_empty;

  always_comb begin
    wr_ptr_nxt = wr_en ? b64_pkg::ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = rd_en ? b64_pkg::ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r + b64_pkg::QCNT_W'(wr_en) - b64_pkg::QCNT_W'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      url_safe_r <= 1'b0;
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      cnt_r      <= '0;
    end else begin
      if (cfg_we) begin
        url_safe_r <= cfg_wdata;
      end
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wr_ptr_r] <= b64_pkg::classify(in_symbol, url_safe_r, in_final_req);
    end
  end

  `B64_ASSERT_IMPLIES(a_front_cnt_bound, 1'b1, cnt_r <= b64_pkg::QCNT_W'(b64_pkg::QDEPTH))
  `B64_ASSERT_NEXT(a_front_fill, (wr_en && !rd_en), cnt_r == $past(cnt_r) + 1'b1)

endmodule

FILE: sv/b64_back.sv
`include "base64_decoder_core_macros.svh"

module b64_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cq_empty,
  output logic                  cq_pop,
  input  b64_pkg::sym_class_t   cq_head,
  output logic                  empty,
  input  logic                  pop,
  output b64_pkg::result_t      out_head
);

  logic [1:0]                  grp_r, grp_nxt;
  logic [5:0]                  prev_r, prev_nxt;
  logic                        third_r, third_nxt;
  logic                        stopped_r, stopped_nxt;

  b64_pkg::result_t            q_r [b64_pkg::QDEPTH];
  logic [b64_pkg::QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [b64_pkg::QCNT_W-1:0]  cnt_r;

  logic                        take;
  logic                        emit;
  logic [7:0]                  byte_val;
  logic                        wr_en;
  logic                        rd_en;
  b64_pkg::result_t            res;

  assign take   = !cq_empty && (cnt_r != b64_pkg::QCNT_W'(b64_pkg::QDEPTH));
  assign cq_pop = take;

  always_comb begin
    grp_nxt     = grp_r;
    prev_nxt    = prev_r;
    third_nxt   = third_r;
    stopped_nxt = stopped_r;
    emit        = 1'b0;
    byte_val    = 8'd0;
    if (take && !stopped_r) begin
      unique case (grp_r)
        b64_pkg::POS_FIRST: begin
          if (!cq_head.valid) begin
            stopped_nxt = 1'b1;
          end else begin
            prev_nxt = cq_head.value;
          end
        end
        b64_pkg::POS_SECOND: begin
          if (!cq_head.valid) begin
            stopped_nxt = 1'b1;
          end else begin
            byte_val = {prev_r, cq_head.value[5:4]};
            emit     = 1'b1;
            prev_nxt = cq_head.value;
          end
        end
        b64_pkg::POS_THIRD: begin
          third_nxt = cq_head.valid;
          if (cq_head.valid) begin
            byte_val = {prev_r[3:0], cq_head.value[5:2]};
            emit     = 1'b1;
            prev_nxt = cq_head.value;
          end
        end
        b64_pkg::POS_FOURTH: begin
          if (cq_head.valid && third_r) begin
            byte_val = {prev_r[1:0], cq_head.value};
            emit     = 1'b1;
          end
        end
        default: begin
        end
      endcase
      grp_nxt = grp_r + 2'd1;
    end

    res.data_byte   = byte_val;
    res.has_byte    = emit;
    res.end_of_text = cq_head.final_req;
    res.halted      = stopped_nxt;

    if (take && cq_head.final_req) begin
      grp_nxt     = b64_pkg::POS_FIRST;
      prev_nxt    = 6'd0;
      third_nxt   = 1'b0;
      stopped_nxt = 1'b0;
    end
  end

  assign wr_en    = take && (emit || cq_head.final_req);
  assign empty    = (cnt_r == '0);
  assign rd_en    = pop && !empty;
  assign out_head = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_r     <= b64_pkg::POS_FIRST;
      prev_r    <= 6'd0;
      third_r   <= 1'b0;
      stopped_r <= 1'b0;
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      cnt_r     <= '0;
    end else begin
      grp_r     <= grp_nxt;
      prev_r    <= prev_nxt;
      third_r   <= third_nxt;
      stopped_r <= stopped_nxt;
      if (wr_en) begin
        wr_ptr_r <= b64_pkg::ptr_inc(wr_ptr_r);
      end
      if (rd_en) begin
        rd_ptr_r <= b64_pkg::ptr_inc(rd_ptr_r);
      end
      cnt_r <= cnt_r + b64_pkg::QCNT_W'(wr_en) - b64_pkg::QCNT_W'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wr_ptr_r] <= res;
    end
  end

  `B64_ASSERT_IMPLIES(a_back_cnt_bound, 1'b1, cnt_r <= b64_pkg::QCNT_W'(b64_pkg::QDEPTH))
  `B64_ASSERT_IMPLIES(a_halt_no_byte, (wr_en && res.halted), !res.has_byte)
  `B64_ASSERT_IMPLIES(a_stopped_silent, (take && stopped_r), !emit)
  `B64_ASSERT_NEXT(a_final_clears, (take && cq_head.final_req), (grp_r == b64_pkg::POS_FIRST) && !stopped_r && !third_r)

endmodule

FILE: sv/base64_decoder_core.sv
// Channel        Handshake        Payload
// input          push / full      in_symbol[7:0], in_final_req
// result         empty / pop      out_data_byte[7:0], out_has_byte, out_end_of_text, out_halted
// configuration  cfg_we           cfg_wdata (url_safe)
//
// One character is accepted per cycle while full is low; results go through the output queue.
// The decode stage sets the rate, updating the group state once per cycle when it takes input.
// Reset is synchronous and active low; it clears the group state, both queues and url_safe.
// Two-entry queues between the stages and at the output let either side stall independently.
module base64_decoder_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_symbol,
  input  logic       in_final_req,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_data_byte,
  output logic       out_has_byte,
  output logic       out_end_of_text,
  output logic       out_halted
);

  logic                 cq_empty;
  logic                 cq_pop;
  b64_pkg::sym_class_t  cq_head;
  b64_pkg::result_t     out_head;

  b64_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .push         (push),
    .full         (full),
    .in_symbol    (in_symbol),
    .in_final_req (in_final_req),
    .cq_empty     (cq_empty),
    .cq_pop       (cq_pop),
    .cq_head      (cq_head)
  );

  b64_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cq_empty (cq_empty),
    .cq_pop   (cq_pop),
    .cq_head  (cq_head),
    .empty    (empty),
    .pop      (pop),
    .out_head (out_head)
  );

  assign out_data_byte   = out_head.data_byte;
  assign out_has_byte    = out_head.has_byte;
  assign out_end_of_text = out_head.end_of_text;
  assign out_halted      = out_head.halted;

endmodule

FILE: tb/tb_base64_decoder_core.sv
`timescale 1ns / 100ps

module tb_base64_decoder_core;

  localparam int DRAIN_CYCLES = 8;
  localparam int CHARS_PER_PHASE = 110;
  localparam int NUM_PHASES = 8;
  localparam logic [7:0] CH_PAD = 8'h3D;

  typedef enum logic [1:0] {ROW_CHAR, ROW_CFG} row_kind_t;
  typedef enum logic [1:0] {EXP_MODEL, EXP_TYPED, EXP_NONE} row_check_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [7:0]        sym;
    logic              fin;
    row_check_t        check;
    b64_pkg::result_t  res;
  } dir_row_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } sextet_t;

  localparam int NUM_DIR = 26;
  localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
    '{ROW_CHAR, "T",   1'b0, EXP_MODEL, '{8'h00, 1'b0, 1'b0, 1'b0}},
    '{ROW_CHAR, "W",   1'b0, EXP_TYPED, '{8'h4D, 1'b1, 1'b0, 1'b0}},
    '{ROW_CHAR, "F",   1'b0, EXP_TYPED, '{8'h61, 1'b1, 1'b0, 1'b0}},
    '{ROW_CHAR, "u",   1'b0, EXP_TYPED, '{8'h6E, 1'b1, 1'b0, 1'b0}},
    '{ROW_CHAR, "/",   1'b0, EXP_NONE,  '{8'h00, 1'b0, 1'b0, 1'b0}},
    '{ROW_CHAR, "/",   1'b0, EXP_TYPED, '{8'hFF, 1'b1, 1'b0, 1'b0}},
    '{ROW_CHAR, "8",   1'b0, EXP_TYPED, '{8'hFF, 1'b1, 1'b0, 1'b0}},
    '{ROW_CHAR, "=",   1'b1, EXP_TYPED, '{8'h00, 1'b0, 1'b1, 1'b0}},
    '{ROW_CHAR, "A",   1'b0, EXP_NONE,  '{8'h00, 1'b0, 1'b0, 1'b0}},
    '{ROW_CHAR, "A",   1'b0, EXP_TYPED, '{8'h00, 1'b1, 1'b0, 1'b0}},
    '{ROW_CHAR, "=",   1'b0, EXP_NONE,  '{8'h00, 1'b0, 1'b0, 1'b0}},
    '{ROW_CHAR, "=",   1'b1, EXP_TYPED, '{8'h00, 1'b0, 1'b1, 1'b0}},
    '{ROW_CHAR, 8'h00, 1'b0, EXP_NONE,  '{8'h00, 1'b0, 1'b0, 1'b0}},
    '{ROW_CHAR, "Q",   1'b0, EXP_NONE,  '{8'h00, 1'b0, 1'b0, 1'b0}},
    '{ROW_CHAR, 8'hFF, 1'b1, EXP_TYPED, '{8'h00, 1'b0, 1'b1, 1'b1}},
    '{ROW_CHAR, "Q",   1'b0, EXP_MODEL, '{8'h00, 1'b0, 1'b0, 1'b0}},
    '{ROW_CHAR, "Q",   1'b1, EXP_TYPED, '{8'h41, 1'b1, 1'b1, 1'b0}},
    '{ROW_CHAR, "Q",   1'b0, EXP_MODEL, '{8'h00, 1'b0, 1'b0, 1'b0}},
    '{ROW_CHAR, "U",   1'b0, EXP_MODEL, '{8'h00, 1'b0, 1'b0, 1'b0}},
    '{ROW_CHAR, "=",   1'b0, EXP_MODEL, '{8'h00, 1'b0, 1'b0, 1'b0}},
    '{ROW_CHAR, "-",   1'b1, EXP_TYPED, '{8'h00, 1'b0, 1'b1, 1'b0}},
    '{ROW_CFG,  8'h01, 1'b0, EXP_NONE,  '{8'h00, 1'b0, 1'b0, 1'b0}},
    '{ROW_CHAR, "-",   1'b0, EXP_MODEL, '{8'h00, 1'b0, 1'b0, 1'b0}},
    '{ROW_CHAR, "_",   1'b0, EXP_MODEL, '{8'h00, 1'b0, 1'b0, 1'b0}},
    '{ROW_CHAR, "-",   1'b0, EXP_MODEL, '{8'h00, 1'b0, 1'b0, 1'b0}},
    '{ROW_CHAR, "_",   1'b1, EXP_MODEL, '{8'h00, 1'b0, 1'b0, 1'b0}}
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic       cfg_wdata = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] in_symbol = 8'h00;
  logic       in_final_req = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] out_data_byte;
  logic       out_has_byte;
  logic       out_end_of_text;
  logic       out_halted;

  logic [1:0] mdl_pos = b64_pkg::POS_FIRST;
  logic [5:0] mdl_prev = 6'd0;
  logic       mdl_third = 1'b0;
  logic       mdl_stopped = 1'b0;
  logic       mdl_url = 1'b0;

  b64_pkg::result_t decoded_q [$];
  int               error_count = 0;
  int               chars_sent = 0;
  int               send_idle_pct = 0;
  int               stall_pct = 0;

  base64_decoder_core u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .push           (push),
    .full           (full),
    .in_symbol      (in_symbol),
    .in_final_req   (in_final_req),
    .empty          (empty),
    .pop            (pop),
    .out_data_byte  (out_data_byte),
    .out_has_byte   (out_has_byte),
    .out_end_of_text(out_end_of_text),
    .out_halted     (out_halted)
  );

  always #5 clk = ~clk;

  function automatic sextet_t sextet_lookup(input logic [7:0] ch, input logic url);
    sextet_t s;
    s.ok = 1'b1;
    s.val = 6'd0;
    if (ch >= b64_pkg::CH_UPPER_A && ch <= b64_pkg::CH_UPPER_Z) begin
      s.val = 6'(ch - b64_pkg::CH_UPPER_A);
    end else if (ch >= b64_pkg::CH_LOWER_A && ch <= b64_pkg::CH_LOWER_Z) begin
      s.val = 6'(ch - b64_pkg::CH_LOWER_A + 8'd26);
    end else if (ch >= b64_pkg::CH_DIGIT_0 && ch <= b64_pkg::CH_DIGIT_9) begin
      s.val = 6'(ch - b64_pkg::CH_DIGIT_0 + 8'd52);
    end else if (ch == b64_pkg::CH_PLUS || (url && ch == b64_pkg::CH_MINUS)) begin
      s.val = 6'd62;
    end else if (ch == b64_pkg::CH_SLASH || (url && ch == b64_pkg::CH_UNDER)) begin
      s.val = 6'd63;
    end else begin
      s.ok = 1'b0;
    end
    return s;
  endfunction

  task automatic decode_char(input logic [7:0] sym, input logic fin, output logic produced,
                             output b64_pkg::result_t res);
    sextet_t    sx;
    logic       emit;
    logic [7:0] byte_val;
    emit = 1'b0;
    byte_val = 8'h00;
    if (!mdl_stopped) begin
      sx = sextet_lookup(sym, mdl_url);
      case (mdl_pos)
        b64_pkg::POS_FIRST: begin
          if (!sx.ok) mdl_stopped = 1'b1;
          else mdl_prev = sx.val;
        end
        b64_pkg::POS_SECOND: begin
          if (!sx.ok) begin
            mdl_stopped = 1'b1;
          end else begin
            byte_val = {mdl_prev, sx.val[5:4]};
            emit = 1'b1;
            mdl_prev = sx.val;
          end
        end
        b64_pkg::POS_THIRD: begin
          if (sx.ok) begin
            byte_val = {mdl_prev[3:0], sx.val[5:2]};
            emit = 1'b1;
            mdl_prev = sx.val;
          end
          mdl_third = sx.ok;
        end
        default: begin
          if (sx.ok && mdl_third) begin
            byte_val = {mdl_prev[1:0], sx.val};
            emit = 1'b1;
          end
        end
      endcase
      mdl_pos = mdl_pos + 2'd1;
    end
    produced = emit || fin;
    res.data_byte = byte_val;
    res.has_byte = emit;
    res.end_of_text = fin;
    res.halted = mdl_stopped;
    if (fin) begin
      mdl_pos = b64_pkg::POS_FIRST;
      mdl_prev = 6'd0;
      mdl_third = 1'b0;
      mdl_stopped = 1'b0;
    end
  endtask

  function automatic logic [7:0] random_alpha();
    int r;
    r = $urandom_range(63);
    if (r < 26) return 8'(b64_pkg::CH_UPPER_A + r);
    if (r < 52) return 8'(b64_pkg::CH_LOWER_A + r - 26);
    if (r < 62) return 8'(b64_pkg::CH_DIGIT_0 + r - 52);
    if (r == 62) return (mdl_url && $urandom_range(1)) ? b64_pkg::CH_MINUS : b64_pkg::CH_PLUS;
    return (mdl_url && $urandom_range(1)) ? b64_pkg::CH_UNDER : b64_pkg::CH_SLASH;
  endfunction

  task automatic send_char(input logic [7:0] sym, input logic fin, input row_check_t check,
                           input b64_pkg::result_t typed);
    logic             produced;
    b64_pkg::result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_symbol <= sym;
    in_final_req <= fin;
    @(posedge clk);
    while (full) @(posedge clk);
    decode_char(sym, fin, produced, res);
    chars_sent++;
    if (check == EXP_TYPED) decoded_q.push_back(typed);
    else if (check == EXP_MODEL && produced) decoded_q.push_back(res);
  endtask

  task automatic send_text();
    int         shape;
    int         len;
    int         pad;
    logic [7:0] ch;
    shape = $urandom_range(99);
    if (shape < 70) begin
      len = 4 * $urandom_range(1, 5);
      pad = $urandom_range(0, 2);
      for (int i = 0; i < len; i++) begin
        ch = (i >= len - pad) ? CH_PAD : random_alpha();
        send_char(ch, i == len - 1, EXP_MODEL, '0);
      end
    end else begin
      len = $urandom_range(1, 10);
      for (int i = 0; i < len; i++) begin
        if (shape >= 85 || $urandom_range(3) == 0) ch = 8'($urandom_range(255));
        else ch = random_alpha();
        send_char(ch, i == len - 1 && shape < 93, EXP_MODEL, '0);
      end
    end
  endtask

  task automatic drain_decoder();
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_url(input logic val);
    cfg_we <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    mdl_url = val;
  endtask

  task automatic check_result();
    b64_pkg::result_t want;
    if (decoded_q.size() == 0) begin
      $error("unexpected result: data_byte=%h has_byte=%b end_of_text=%b halted=%b",
             out_data_byte, out_has_byte, out_end_of_text, out_halted);
      error_count++;
    end else begin
      want = decoded_q.pop_front();
      if (out_data_byte !== want.data_byte) begin
        $error("data_byte: expected %h, got %h", want.data_byte, out_data_byte);
        error_count++;
      end
      if (out_has_byte !== want.has_byte) begin
        $error("has_byte: expected %b, got %b", want.has_byte, out_has_byte);
        error_count++;
      end
      if (out_end_of_text !== want.end_of_text) begin
        $error("end_of_text: expected %b, got %b", want.end_of_text, out_end_of_text);
        error_count++;
      end
      if (out_halted !== want.halted) begin
        $error("halted: expected %b, got %b", want.halted, out_halted);
        error_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_result();
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NUM_DIR; i++) begin
      if (DIR_ROWS[i].kind == ROW_CFG) begin
        push <= 1'b0;
        drain_decoder();
        write_url(DIR_ROWS[i].sym[0]);
      end else begin
        send_char(DIR_ROWS[i].sym, DIR_ROWS[i].fin, DIR_ROWS[i].check, DIR_ROWS[i].res);
      end
    end
    push <= 1'b0;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_decoder();
      write_url(ph[0]);
      case (ph / 2)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 80;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 80;
        end
        default: begin
          send_idle_pct = 22;
          stall_pct = 22;
        end
      endcase
      while (chars_sent < NUM_DIR + (ph + 1) * CHARS_PER_PHASE) send_text();
      push <= 1'b0;
    end

    drain_decoder();
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
